### design/bdh_pkg.sv
// Shared constants, types and helper functions of the button debouncer with hold detection.
`default_nettype none
package bdh_pkg;

	localparam int NUM_BUTTONS   = 6;
	localparam int PIN_BITS      = 6;
	localparam int MASK_BITS     = 6;
	localparam int TS_BITS       = 64;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int DEB_BITS      = 10;
	localparam int HOLD_BITS     = 16;
	// Thresholds in microseconds: (1023 + 1) * 1000 and 65535 * 1000 set these widths.
	localparam int DEB_THR_BITS  = 20;
	localparam int HOLD_THR_BITS = 26;
	localparam int BTN_A         = NUM_BUTTONS - 2;
	localparam int BTN_B         = NUM_BUTTONS - 1;

	localparam logic [DEB_THR_BITS-1:0]  DEB_THR_RST  = DEB_THR_BITS'((30 + 1) * 1000);
	localparam logic [HOLD_THR_BITS-1:0] EXIT_THR_RST = HOLD_THR_BITS'(2000 * 1000);
	localparam logic [HOLD_THR_BITS-1:0] FS_THR_RST   = HOLD_THR_BITS'(5000 * 1000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DEBOUNCE      = 2'd0,
		REG_EXIT_HOLD     = 2'd1,
		REG_FAILSAFE_HOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic level_nxt;
		logic before_nxt;
		logic press_take;
	} lane_stat_t;

	typedef struct packed {
		logic [MASK_BITS-1:0] held_mask;
		logic [MASK_BITS-1:0] pressed_mask;
		logic [MASK_BITS-1:0] released_mask;
		logic                 exit_requested;
		logic                 fail_safe;
		logic                 exit_combo;
	} result_t;

	// (ms + 1) * 1000: a difference d satisfies d / 1000 > ms exactly when d reaches this.
	function automatic logic [DEB_THR_BITS-1:0] deb_thr(input logic [DEB_BITS-1:0] ms);
		logic [DEB_THR_BITS-1:0] v;
		v = DEB_THR_BITS'(ms) + DEB_THR_BITS'(1);
		return (v << 10) - (v << 4) - (v << 3);
	endfunction

	// ms * 1000: d / 1000 >= ms exactly when d reaches this.
	function automatic logic [HOLD_THR_BITS-1:0] hold_thr(input logic [HOLD_BITS-1:0] ms);
		logic [HOLD_THR_BITS-1:0] v;
		v = HOLD_THR_BITS'(ms);
		return (v << 10) - (v << 4) - (v << 3);
	endfunction

endpackage
`default_nettype wire

### design/bdh_in_if.sv
// Pin sample channel: valid, ready, pin levels and timestamp.
`default_nettype none
interface bdh_in_if;
	import bdh_pkg::*;
	logic                valid;
	logic                ready;
	logic [PIN_BITS-1:0] raw_pins;
	logic [TS_BITS-1:0]  now_us;
	modport source (output valid, raw_pins, now_us, input ready);
	modport sink (input valid, raw_pins, now_us, output ready);
endinterface
`default_nettype wire

### design/bdh_out_if.sv
// Result channel: valid, ready and the debounced masks and exit flags.
`default_nettype none
interface bdh_out_if;
	import bdh_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MASK_BITS-1:0] held_mask;
	logic [MASK_BITS-1:0] pressed_mask;
	logic [MASK_BITS-1:0] released_mask;
	logic                 exit_requested;
	logic                 fail_safe;
	logic                 exit_combo;
	modport source (output valid, held_mask, pressed_mask, released_mask, exit_requested,
		fail_safe, exit_combo, input ready);
	modport sink (input valid, held_mask, pressed_mask, released_mask, exit_requested,
		fail_safe, exit_combo, output ready);
endinterface
`default_nettype wire

### design/bdh_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
`default_nettype none
interface bdh_cfg_if;
	import bdh_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  reg_index;
	logic [CFG_DATA_BITS-1:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

### design/bdh_lane.sv
// One button lane: debounced level, previous level and last change time.
`default_nettype none
module bdh_lane (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  wire logic                            raw_level,
	input  wire logic [bdh_pkg::TS_BITS-1:0]     now_us,
	input  wire logic [bdh_pkg::DEB_THR_BITS-1:0] deb_thr,
	output bdh_pkg::lane_stat_t                  stat
);
	import bdh_pkg::*;

	logic               level_q;
	logic               before_q;
	logic [TS_BITS-1:0] change_time_q;
	logic [TS_BITS-1:0] diff;
	logic               old_enough;
	logic               change;

	assign diff       = now_us - change_time_q;
	assign old_enough = (|diff[TS_BITS-1:DEB_THR_BITS]) || (diff[DEB_THR_BITS-1:0] >= deb_thr);
	assign change     = (raw_level ^ level_q) & old_enough;

	always_comb begin
		stat.level_nxt  = change ? raw_level : level_q;
		stat.before_nxt = change ? level_q : before_q;
		stat.press_take = change & raw_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b0;
			before_q      <= 1'b0;
			change_time_q <= '0;
		end else if (take) begin
			level_q  <= stat.level_nxt;
			before_q <= stat.before_nxt;
			if (change) begin
				change_time_q <= now_us;
			end
		end
	end
endmodule
`default_nettype wire

### design/bdh_merge.sv
// Merge of the lanes: edge masks and exit hold flags from the updated levels.
`default_nettype none
module bdh_merge (
	input  wire logic [bdh_pkg::NUM_BUTTONS-1:0]   level,
	input  wire logic [bdh_pkg::NUM_BUTTONS-1:0]   prev_level,
	input  wire logic [bdh_pkg::TS_BITS-1:0]       exit_diff,
	input  wire logic [bdh_pkg::HOLD_THR_BITS-1:0] exit_thr,
	input  wire logic [bdh_pkg::HOLD_THR_BITS-1:0] fs_thr,
	output bdh_pkg::result_t                       res
);
	import bdh_pkg::*;

	logic [NUM_BUTTONS-1:0] pressed;
	logic [NUM_BUTTONS-1:0] released;
	logic                   high_part;
	logic                   ex;
	logic                   fs;

	assign pressed   = level & ~prev_level;
	assign released  = ~level & prev_level;
	assign high_part = |exit_diff[TS_BITS-1:HOLD_THR_BITS];
	assign ex = level[BTN_B] && (high_part || (exit_diff[HOLD_THR_BITS-1:0] >= exit_thr));
	assign fs = level[BTN_B] && (high_part || (exit_diff[HOLD_THR_BITS-1:0] >= fs_thr));

	always_comb begin
		res.held_mask      = MASK_BITS'(level);
		res.pressed_mask   = MASK_BITS'(pressed);
		res.released_mask  = MASK_BITS'(released);
		res.exit_requested = ex;
		res.fail_safe      = fs;
		res.exit_combo     = ex || fs || (pressed[BTN_A] && pressed[BTN_B]);
	end
endmodule
`default_nettype wire

### design/button_debounce_hold_detector.sv
// Top level of the button debouncer with hold detection.
// Each item is one sample of the six active-low button pins with a free-running
// microsecond timestamp, and each item gives exactly one result. A button's new
// level is taken only once more than the debounce time in whole milliseconds has
// passed since its last accepted change; the last button is the exit button and
// the one before it is button A. The block takes one item per clock cycle while
// back-pressure does not stall it; each result passes the first stage and the
// output register: in the cycle of acceptance one lane per button does a 64-bit
// subtract and compare against the debounce threshold and updates its state, so
// the next item can follow at once; the merge stage then compares the exit
// button's hold time and forms the masks into the output register. Hold times
// are compared in microseconds against thresholds that are multiplied by 1000
// when a register is written, so no division takes place. The configuration
// channel is always ready; writes to an index beyond the three registers are
// ignored, and writes should only be made while no item is in flight.
`default_nettype none
module button_debounce_hold_detector (
	input  wire logic clk,
	input  wire logic arst_n,
	bdh_in_if.sink    sample,
	bdh_out_if.source result,
	bdh_cfg_if.sink   cfg
);
	import bdh_pkg::*;

	// Configuration, held as thresholds in microseconds.
	logic [DEB_THR_BITS-1:0]  deb_thr_q;
	logic [HOLD_THR_BITS-1:0] exit_thr_q;
	logic [HOLD_THR_BITS-1:0] fs_thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_thr_q  <= DEB_THR_RST;
			exit_thr_q <= EXIT_THR_RST;
			fs_thr_q   <= FS_THR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_DEBOUNCE:      deb_thr_q  <= deb_thr(cfg.wdata[DEB_BITS-1:0]);
				REG_EXIT_HOLD:     exit_thr_q <= hold_thr(cfg.wdata[HOLD_BITS-1:0]);
				REG_FAILSAFE_HOLD: fs_thr_q   <= hold_thr(cfg.wdata[HOLD_BITS-1:0]);
				default: ;
			endcase
		end
	end

	// Handshake: the first stage moves on whenever the output register is free or being
	// emptied, and it takes a new item whenever it is empty or moves on.
	logic valid_s1;
	logic out_valid_q;
	logic adv_out;
	logic take;

	assign adv_out      = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || adv_out;
	assign take         = sample.valid && sample.ready;

	// Button lanes. Pins are active low; buttons with no pin bit read as released.
	logic [NUM_BUTTONS-1:0] raw_level;
	lane_stat_t             stat [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] level_nxt;
	logic [NUM_BUTTONS-1:0] before_nxt;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		if (i < PIN_BITS) begin : g_pin
			assign raw_level[i] = ~sample.raw_pins[i];
		end else begin : g_nopin
			assign raw_level[i] = 1'b0;
		end

		bdh_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.take      (take),
			.raw_level (raw_level[i]),
			.now_us    (sample.now_us),
			.deb_thr   (deb_thr_q),
			.stat      (stat[i])
		);

		assign level_nxt[i]  = stat[i].level_nxt;
		assign before_nxt[i] = stat[i].before_nxt;
	end

	// Press time of the exit button. When the exit button's press is taken with
	// this very item, its hold time is zero.
	logic [TS_BITS-1:0] exit_press_time_q;
	logic [TS_BITS-1:0] exit_diff;

	assign exit_diff = stat[BTN_B].press_take ? '0 : (sample.now_us - exit_press_time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_press_time_q <= '0;
		end else if (take && stat[BTN_B].press_take) begin
			exit_press_time_q <= sample.now_us;
		end
	end

	// First pipeline stage: updated levels and the exit button's hold time.
	logic [NUM_BUTTONS-1:0] level_s1;
	logic [NUM_BUTTONS-1:0] before_s1;
	logic [TS_BITS-1:0]     exit_diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_s1     <= level_nxt;
			before_s1    <= before_nxt;
			exit_diff_s1 <= exit_diff;
		end
	end

	// Merge stage and output register.
	result_t res;
	result_t res_q;

	bdh_merge u_merge (
		.level      (level_s1),
		.prev_level (before_s1),
		.exit_diff  (exit_diff_s1),
		.exit_thr   (exit_thr_q),
		.fs_thr     (fs_thr_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			res_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.held_mask      = res_q.held_mask;
	assign result.pressed_mask   = res_q.pressed_mask;
	assign result.released_mask  = res_q.released_mask;
	assign result.exit_requested = res_q.exit_requested;
	assign result.fail_safe      = res_q.fail_safe;
	assign result.exit_combo     = res_q.exit_combo;
endmodule
`default_nettype wire

### bench/button_debounce_hold_detector_test.sv
// Self-checking testbench of the button debouncer with hold detection.
module button_debounce_hold_detector_test;
	import bdh_pkg::*;

	// Limit on the length of the run; the slowest correct run stays well within it.
	localparam int CYCLE_LIMIT = 400_000;

	// The register index channel is two bits wide but only three indexes name a register.
	// Writes to the remaining index must leave every register untouched.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdh_in_if  sample_ch ();
	bdh_out_if result_ch ();
	bdh_cfg_if cfg_ch ();

	button_debounce_hold_detector DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor state: a private copy of the debounced levels, the per-button change
	// times, the exit button's press time and the three registers.
	logic [MASK_BITS-1:0]     debounced;
	logic [MASK_BITS-1:0]     debounced_before;
	logic [TS_BITS-1:0]       change_at [NUM_BUTTONS];
	logic [TS_BITS-1:0]       exit_pressed_at;
	logic [DEB_BITS-1:0]      cfg_debounce;
	logic [HOLD_BITS-1:0]     cfg_exit_hold;
	logic [HOLD_BITS-1:0]     cfg_failsafe_hold;

	// Results owed by the block, oldest first.
	result_t pending_results [$];

	int          mismatch_count = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          cycle_count = 0;
	logic [TS_BITS-1:0] sample_time = '0;

	// Works out the result of one pin sample and advances the predictor state. Every
	// time difference is taken modulo 2^64 and truncated to whole milliseconds.
	function automatic result_t debounce_step(input logic [PIN_BITS-1:0] pins,
		input logic [TS_BITS-1:0] ts);
		logic [MASK_BITS-1:0] level_in;
		logic [TS_BITS-1:0]   held_for_ms;
		result_t              r;
		// The pins are active low, so a zero bit is a pressed button.
		level_in = ~pins[MASK_BITS-1:0];
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (level_in[i] != debounced[i] &&
				(ts - change_at[i]) / 64'd1000 > TS_BITS'(cfg_debounce)) begin
				debounced_before[i] = debounced[i];
				debounced[i] = level_in[i];
				change_at[i] = ts;
				if (i == BTN_B && level_in[i])
					exit_pressed_at = ts;
			end
		end
		held_for_ms = (ts - exit_pressed_at) / 64'd1000;
		r.held_mask = debounced;
		r.pressed_mask = debounced & ~debounced_before;
		r.released_mask = ~debounced & debounced_before;
		r.exit_requested = debounced[BTN_B] && held_for_ms >= TS_BITS'(cfg_exit_hold);
		r.fail_safe = debounced[BTN_B] && held_for_ms >= TS_BITS'(cfg_failsafe_hold);
		r.exit_combo = r.exit_requested || r.fail_safe ||
			(r.pressed_mask[BTN_A] && r.pressed_mask[BTN_B]);
		return r;
	endfunction

	// Sends one pin sample. The sender works in bursts: between bursts it drops valid
	// for a gap of random length, and sometimes for none at all. Valid is left high
	// after acceptance so that back-to-back items never lower and raise it in one step.
	task automatic send_sample(input logic [PIN_BITS-1:0] pins, input logic [TS_BITS-1:0] ts);
		while (gap_left > 0) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_pins <= pins;
		sample_ch.now_us <= ts;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		pending_results.push_back(debounce_step(pins, ts));
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	// Stops sending and waits until every owed result has been taken. Since every item
	// gives exactly one result, the block is idle once the queue is empty.
	task automatic wait_for_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register and mirrors the write in the predictor. Valid is left high so
	// that a run of writes follows without a break; write_registers lowers it.
	task automatic put_register(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_DEBOUNCE: begin
				cfg_debounce = data[DEB_BITS-1:0];
			end
			REG_EXIT_HOLD: begin
				cfg_exit_hold = data;
			end
			REG_FAILSAFE_HOLD: begin
				cfg_failsafe_hold = data;
			end
			default: begin
			end
		endcase
	endtask

	// Writes all three registers, then a write of random data to the unused index, which
	// must change nothing. Only called once the block has drained.
	task automatic write_registers(input logic [CFG_DATA_BITS-1:0] debounce_data,
		input logic [CFG_DATA_BITS-1:0] exit_data, input logic [CFG_DATA_BITS-1:0] failsafe_data);
		put_register(REG_DEBOUNCE, debounce_data);
		put_register(REG_EXIT_HOLD, exit_data);
		put_register(REG_FAILSAFE_HOLD, failsafe_data);
		put_register(REG_UNUSED, CFG_DATA_BITS'($urandom));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// One human-like gesture: some contact bounce, then a settled pin pattern sampled
	// around the end of the debounce window, then a hold sampled around the exit and
	// fail-safe thresholds. Boundary samples land exactly on, or one microsecond short
	// of, the instant at which the block must change its mind.
	task automatic press_gesture();
		logic [PIN_BITS-1:0] target;
		logic [PIN_BITS-1:0] flip;
		int unsigned         k;
		target = PIN_BITS'($urandom);
		// Favour the exit button so that holds are common.
		if ($urandom_range(0, 2) != 0)
			target[BTN_B] = 1'b0;
		repeat ($urandom_range(0, 3)) begin
			sample_time += 64'($urandom_range(0, 3000));
			send_sample(PIN_BITS'($urandom), sample_time);
		end
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 3))
				0: begin
					k = $urandom_range(0, NUM_BUTTONS - 1);
					sample_time = change_at[k] + 64'(cfg_debounce + 1) * 64'd1000 -
						64'($urandom_range(0, 1));
				end
				1, 2: begin
					sample_time += 64'($urandom_range(0, (cfg_debounce + 2) * 1000));
				end
				default: begin
					sample_time += 64'($urandom_range(0, 2000));
				end
			endcase
			// Now and then a single pin glitches during the settled part.
			flip = ($urandom_range(0, 7) == 0) ? PIN_BITS'(1 << $urandom_range(0, 5)) : '0;
			send_sample(target ^ flip, sample_time);
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 3))
				0: begin
					sample_time = exit_pressed_at + 64'(cfg_exit_hold) * 64'd1000 -
						64'($urandom_range(0, 1));
				end
				1: begin
					sample_time = exit_pressed_at + 64'(cfg_failsafe_hold) * 64'd1000 -
						64'($urandom_range(0, 1));
				end
				default: begin
					sample_time += 64'($urandom_range(0, (cfg_failsafe_hold + 100) * 500));
				end
			endcase
			send_sample(target, sample_time);
		end
	endtask

	// Straight after reset, with the reset register values: a press inside the
	// debounce window is refused, one exactly past it is taken, and a release that comes
	// one microsecond short of the window's end is still refused.
	task automatic test_debounce_window();
		send_sample(6'h3F, 64'd0);
		send_sample(6'h00, 64'd30_999);
		send_sample(6'h00, 64'd31_000);
		send_sample(6'h3F, 64'd61_999);
	endtask

	// The exit button was pressed at 31 ms above. The exit and fail-safe flags must rise
	// exactly at their thresholds; then a release of all buttons, a press of the exit
	// button alone and a swap to button A alone.
	task automatic test_exit_hold();
		send_sample(6'h00, 64'd2_030_999);
		send_sample(6'h00, 64'd2_031_000);
		send_sample(6'h00, 64'd5_030_999);
		send_sample(6'h00, 64'd5_031_000);
		send_sample(6'h3F, 64'd5_031_000);
		send_sample(6'h1F, 64'd5_100_000);
		send_sample(6'h2F, 64'd5_200_000);
	endtask

	// The exit button is pressed just before the timestamp wraps and held across the
	// wrap; the hold must still be measured modulo 2^64. The largest timestamp and zero
	// are both sent.
	task automatic test_timestamp_wrap();
		logic [TS_BITS-1:0] wrap_at;
		wrap_at = 64'd0 - 64'd500;
		send_sample(6'h1F, wrap_at);
		send_sample(6'h1F, wrap_at + 64'd1_999_999);
		send_sample(6'h1F, wrap_at + 64'd2_000_000);
		send_sample(6'h3F, '1);
		send_sample(6'h00, 64'd0);
	endtask

	// Register extremes: all zero, where one whole millisecond is enough to debounce and
	// any hold raises both flags at once; then all ones in debounce and exit hold, so
	// that the debounce value is cut to its ten bits and the exit hold is at its largest.
	task automatic test_register_extremes();
		logic [TS_BITS-1:0] base;
		logic [TS_BITS-1:0] press_at;
		base = 64'd10_000_000;
		wait_for_results();
		write_registers(16'd0, 16'd0, 16'd0);
		send_sample(6'h3F, base);
		send_sample(6'h00, base + 64'd999);
		send_sample(6'h00, base + 64'd1000);
		wait_for_results();
		write_registers(16'hFFFF, 16'hFFFF, 16'd60_000);
		send_sample(6'h3F, base + 64'd1000 + 64'd1_023_999);
		send_sample(6'h3F, base + 64'd1000 + 64'd1_024_000);
		press_at = base + 64'd1000 + 64'd2_048_000;
		send_sample(6'h00, press_at);
		send_sample(6'h00, press_at + 64'd59_999_999);
		send_sample(6'h00, press_at + 64'd60_000_000);
		send_sample(6'h00, press_at + 64'd65_535_000);
	endtask

	// One random phase under fixed register values. Most items form gestures; a few carry
	// a wholly random timestamp, which also sends time backwards for the next gesture.
	// Occasionally the sender stops until everything owed has come back.
	task automatic run_phase(input int unsigned deb_ms, input int unsigned exit_ms,
		input int unsigned failsafe_ms, input bit near_wrap, input int count);
		int target_count;
		wait_for_results();
		// Bits above the ten of the debounce register are set at random; they must be cut.
		write_registers({PIN_BITS'($urandom), DEB_BITS'(deb_ms)},
			HOLD_BITS'(exit_ms), HOLD_BITS'(failsafe_ms));
		if (near_wrap)
			sample_time = '1 - 64'($urandom_range(0, 50_000_000));
		target_count = items_sent + count;
		while (items_sent < target_count) begin
			if ($urandom_range(0, 29) == 0)
				send_sample(PIN_BITS'($urandom), {$urandom, $urandom});
			else
				press_gesture();
			if ($urandom_range(0, 99) == 0)
				wait_for_results();
		end
	endtask

	// Random gestures under several register settings: the reset values on a human time
	// scale, short random windows, a slow debounce with a long fail-safe, two
	// phases that run through the timestamp wrap, and zero debounce.
	task automatic test_random_gestures();
		run_phase(30, 2000, 5000, 1'b0, 170);
		run_phase($urandom_range(0, 40), $urandom_range(0, 300), $urandom_range(0, 600),
			1'b0, 170);
		run_phase(1000, 1000, 60_000, 1'b1, 120);
		run_phase($urandom_range(0, 40), $urandom_range(0, 300), $urandom_range(0, 600),
			1'b1, 200);
		run_phase(0, $urandom_range(0, 50), 0, 1'b0, 190);
	endtask

	task automatic compare_field(input string field, input logic [MASK_BITS-1:0] want,
		input logic [MASK_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: every result taken at a clock edge is checked against the oldest owed
	// result. Ready follows a repeating stall pattern that is redrawn at random;
	// some patterns never stall, so there are stretches with no back-pressure at all.
	initial begin
		logic [7:0] stall_pattern;
		int         pattern_age;
		int         pattern_bit;
		result_t    want;
		stall_pattern = 8'hFF;
		pattern_age = 0;
		pattern_bit = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no sample waiting for it");
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					compare_field("held_mask", want.held_mask, result_ch.held_mask);
					compare_field("pressed_mask", want.pressed_mask, result_ch.pressed_mask);
					compare_field("released_mask", want.released_mask, result_ch.released_mask);
					compare_field("exit_requested", MASK_BITS'(want.exit_requested),
						MASK_BITS'(result_ch.exit_requested));
					compare_field("fail_safe", MASK_BITS'(want.fail_safe),
						MASK_BITS'(result_ch.fail_safe));
					compare_field("exit_combo", MASK_BITS'(want.exit_combo),
						MASK_BITS'(result_ch.exit_combo));
				end
			end
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: stall_pattern = 8'hFF;
					1: stall_pattern = 8'($urandom);
					default: stall_pattern = 8'($urandom) | 8'($urandom);
				endcase
				if (stall_pattern == 8'h00)
					stall_pattern = 8'h01;
			end
			pattern_age--;
			result_ch.ready <= stall_pattern[pattern_bit];
			pattern_bit = (pattern_bit + 1) % 8;
		end
	end

	// A hung handshake would otherwise stall the run for ever.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sample_ch.valid <= 1'b0;
		sample_ch.raw_pins <= '1;
		sample_ch.now_us <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.reg_index <= REG_DEBOUNCE;
		cfg_ch.wdata <= '0;
		// Predictor reset: all buttons released, all times zero, reset register values.
		debounced = '0;
		debounced_before = '0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			change_at[i] = '0;
		exit_pressed_at = '0;
		cfg_debounce = DEB_BITS'(30);
		cfg_exit_hold = HOLD_BITS'(2000);
		cfg_failsafe_hold = HOLD_BITS'(5000);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed tests run on one another's state, so their order matters.
		test_debounce_window();
		test_exit_hold();
		test_timestamp_wrap();
		test_register_extremes();
		test_random_gestures();

		// Everything has been sent; collect the last results and then keep watching the result
		// side in case the block produces something it does not owe.
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
